// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define TLIK_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define TLIK_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TLIK_ASSERT(lbl, clk, rst, prop, msg)
`define TLIK_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ----- rtl/tlik_pkg.sv -----
// ----------------------------------------------------------------------------
// tlik_pkg
// Widths, constants, types and the arctangent table of the two-link IK block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tlik_pkg;

   localparam int XW         = 18;
   localparam int LW         = 16;
   localparam int AW         = 16;
   localparam int NUMW       = 37;
   localparam int ABSW       = 36;
   localparam int DENW       = 33;
   localparam int QW         = 15;
   localparam int DIVW       = 48;
   localparam int C2W        = 16;
   localparam int SQW        = 29;
   localparam int TW         = 31;
   localparam int KW         = 32;
   localparam int PW         = 50;
   localparam int ABW        = 51;
   localparam int CW         = 56;
   localparam int ZW         = 28;

   localparam int CORDIC_STEPS = 16;
   localparam int ATAN_LEN     = 24;
   localparam int CORDIC_ITERS = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;

   localparam logic signed [ZW-1:0] HALF_PI_Q24 = 28'sd26353589;
   localparam logic [QW-1:0]        ONE_Q14     = 15'd16384;
   localparam logic [LW-1:0]        UPPER_RESET = 16'd16384;
   localparam logic [LW-1:0]        LOWER_RESET = 16'd8192;
   localparam logic signed [AW-1:0] ELBOW_LIMIT = 16'sd26000;

   typedef enum logic [0:0] {
      CSR_UPPER_LINK = 1'b0,
      CSR_LOWER_LINK = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] y;
      logic                 unreach;
   } side_type;

   typedef struct packed {
      logic [DENW-1:0] r;
      logic [QW-1:0]   q;
      logic [DIVW-1:0] n;
      logic [DENW-1:0] den;
      logic            neg;
   } div_type;

   typedef struct packed {
      logic [SQW-1:0]        rem;
      logic [QW-1:0]         root;
      logic signed [C2W-1:0] c2;
   } sqrt_type;

   function automatic logic signed [ZW-1:0] atan_q24(input int idx);
      logic signed [ZW-1:0] v;
      case (idx)
         0:       v = 28'sd13176795;
         1:       v = 28'sd7778716;
         2:       v = 28'sd4110060;
         3:       v = 28'sd2086331;
         4:       v = 28'sd1047214;
         5:       v = 28'sd524117;
         6:       v = 28'sd262123;
         7:       v = 28'sd131069;
         8:       v = 28'sd65536;
         9:       v = 28'sd32768;
         10:      v = 28'sd16384;
         11:      v = 28'sd8192;
         12:      v = 28'sd4096;
         13:      v = 28'sd2048;
         14:      v = 28'sd1024;
         15:      v = 28'sd512;
         16:      v = 28'sd256;
         17:      v = 28'sd128;
         18:      v = 28'sd64;
         19:      v = 28'sd32;
         20:      v = 28'sd16;
         21:      v = 28'sd8;
         22:      v = 28'sd4;
         23:      v = 28'sd2;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

// ----- rtl/tlik_req_if.sv -----
// ----------------------------------------------------------------------------
// tlik_req_if
// Request channel: target point, valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tlik_req_if;
   logic                           valid;
   logic                           ready;
   logic signed [tlik_pkg::XW-1:0] target_x;
   logic signed [tlik_pkg::XW-1:0] target_y;

   modport source (output valid, output target_x, output target_y, input ready);
   modport sink   (input valid, input target_x, input target_y, output ready);
endinterface

// ----- rtl/tlik_rsp_if.sv -----
// ----------------------------------------------------------------------------
// tlik_rsp_if
// Response channel: joint angles and reach flag, valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tlik_rsp_if;
   logic                           valid;
   logic                           ready;
   logic signed [tlik_pkg::AW-1:0] shoulder_angle;
   logic signed [tlik_pkg::AW-1:0] elbow_angle;
   logic                           unreachable;

   modport source (output valid, output shoulder_angle, output elbow_angle,
                   output unreachable, input ready);
   modport sink   (input valid, input shoulder_angle, input elbow_angle,
                   input unreachable, output ready);
endinterface

// ----- rtl/tlik_cordic.sv -----
// ----------------------------------------------------------------------------
// tlik_cordic
// Pipelined CORDIC vectoring atan2, one iteration per stage, Q3.13 result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tlik_cordic (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                en,
   input  logic                                in_valid,
   input  logic                                in_tag,
   input  logic signed [tlik_pkg::CW-1:0]      in_y,
   input  logic signed [tlik_pkg::CW-1:0]      in_x,
   output logic                                out_valid,
   output logic                                out_tag,
   output logic signed [tlik_pkg::AW-1:0]      out_angle
);

   localparam int N = tlik_pkg::CORDIC_ITERS;

   logic signed [tlik_pkg::CW-1:0] cx_ff [0:N];
   logic signed [tlik_pkg::CW-1:0] cy_ff [0:N];
   logic signed [tlik_pkg::ZW-1:0] cz_ff [0:N];
   logic                           vld_ff [0:N];
   logic                           tag_ff [0:N];
   logic                           zero_ff [0:N];

   logic signed [tlik_pkg::CW-1:0] x0_in, y0_in;
   logic signed [tlik_pkg::ZW-1:0] z0_in;

   // quadrant fold: bring x onto the right half plane
   always_comb begin
      x0_in = in_x;
      y0_in = in_y;
      z0_in = '0;
      if (in_x < 0) begin
         if (in_y >= 0) begin
            x0_in = in_y;
            y0_in = -in_x;
            z0_in = tlik_pkg::HALF_PI_Q24;
         end else begin
            x0_in = -in_y;
            y0_in = in_x;
            z0_in = -tlik_pkg::HALF_PI_Q24;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_valid;
      end
      if (en) begin
         cx_ff[0]   <= x0_in;
         cy_ff[0]   <= y0_in;
         cz_ff[0]   <= z0_in;
         tag_ff[0]  <= in_tag;
         zero_ff[0] <= (in_x == 0) && (in_y == 0);
      end
   end

   for (genvar i = 0; i < N; i++) begin : g_iter
      logic signed [tlik_pkg::CW-1:0] x_in, y_in;
      logic signed [tlik_pkg::ZW-1:0] z_in;

      always_comb begin
         if (cy_ff[i] >= 0) begin
            x_in = cx_ff[i] + (cy_ff[i] >>> i);
            y_in = cy_ff[i] - (cx_ff[i] >>> i);
            z_in = cz_ff[i] + tlik_pkg::atan_q24(i);
         end else begin
            x_in = cx_ff[i] - (cy_ff[i] >>> i);
            y_in = cy_ff[i] + (cx_ff[i] >>> i);
            z_in = cz_ff[i] - tlik_pkg::atan_q24(i);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i+1] <= 1'b0;
         end else if (en) begin
            vld_ff[i+1] <= vld_ff[i];
         end
         if (en) begin
            cx_ff[i+1]   <= x_in;
            cy_ff[i+1]   <= y_in;
            cz_ff[i+1]   <= z_in;
            tag_ff[i+1]  <= tag_ff[i];
            zero_ff[i+1] <= zero_ff[i];
         end
      end
   end

   // round half away from zero, Q24 to Q13
   logic [tlik_pkg::ZW-1:0]        zmag;
   logic [tlik_pkg::ZW-1:0]        zrnd;
   logic [tlik_pkg::AW-1:0]        amag;
   logic signed [tlik_pkg::AW-1:0] angle_in;
   logic signed [tlik_pkg::AW-1:0] angle_ff;
   logic                           ovld_ff;
   logic                           otag_ff;

   always_comb begin
      zmag     = (cz_ff[N] < 0) ? tlik_pkg::ZW'(-cz_ff[N]) : tlik_pkg::ZW'(cz_ff[N]);
      zrnd     = (zmag + tlik_pkg::ZW'(1024)) >> 11;
      amag     = zrnd[tlik_pkg::AW-1:0];
      angle_in = zero_ff[N] ? '0 : ((cz_ff[N] < 0) ? -$signed(amag) : $signed(amag));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ovld_ff <= 1'b0;
      end else if (en) begin
         ovld_ff <= vld_ff[N];
      end
      if (en) begin
         angle_ff <= angle_in;
         otag_ff  <= tag_ff[N];
      end
   end

   assign out_valid = ovld_ff;
   assign out_tag   = otag_ff;
   assign out_angle = angle_ff;

endmodule

// ----- rtl/two_link_inverse_kinematics_top.sv -----
// ----------------------------------------------------------------------------
// two_link_inverse_kinematics_top
// Two-link planar arm inverse kinematics, elbow branch with sin2 >= 0.
// ----------------------------------------------------------------------------
// Takes one target point per cycle while the response is not stalled and
// returns shoulder and elbow angles in Q3.13 radians, in order (law of
// cosines, a 15-stage restoring divider, a 15-stage square root, the k1/k2
// products, then two CORDIC pipelines of the default 16 steps side by side).
// A stalled response holds the whole pipeline; the user must program the link
// lengths through the csr port only while no request is in flight (unchecked).
`timescale 1ns / 1ps
`include "assert_macros.svh"

module two_link_inverse_kinematics_top (
   input  logic                          clock,
   input  logic                          reset,
   tlik_req_if.sink                      req_ch,
   tlik_rsp_if.source                    rsp_ch,
   input  logic                          csr_write_enable,
   input  logic [0:0]                    csr_index,
   input  logic [tlik_pkg::LW-1:0]       csr_write_data
);

   localparam int XW   = tlik_pkg::XW;
   localparam int LW   = tlik_pkg::LW;
   localparam int QW   = tlik_pkg::QW;
   localparam int DENW = tlik_pkg::DENW;
   localparam int DIVW = tlik_pkg::DIVW;
   localparam int SQW  = tlik_pkg::SQW;
   localparam int TW   = tlik_pkg::TW;
   localparam int KW   = tlik_pkg::KW;
   localparam int PW   = tlik_pkg::PW;
   localparam int ABW  = tlik_pkg::ABW;
   localparam int CW   = tlik_pkg::CW;
   localparam int C2W  = tlik_pkg::C2W;

   // link length registers
   logic [LW-1:0] upper_ff, lower_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         upper_ff <= tlik_pkg::UPPER_RESET;
         lower_ff <= tlik_pkg::LOWER_RESET;
      end else if (csr_write_enable) begin
         unique case (tlik_pkg::csr_index_type'(csr_index))
            tlik_pkg::CSR_UPPER_LINK: upper_ff <= csr_write_data;
            tlik_pkg::CSR_LOWER_LINK: lower_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   logic en;
   logic out_vld_ff;

   assign en           = !out_vld_ff || rsp_ch.ready;
   assign req_ch.ready = en;

   // S1: squares
   tlik_pkg::side_type            s1_side_ff, s1_side_in;
   logic signed [2*XW-1:0]        s1_xx_ff, s1_yy_ff;
   logic [2*LW-1:0]               s1_l1sq_ff, s1_l2sq_ff, s1_l1l2_ff;
   logic                          s1_vld_ff;

   always_comb begin
      s1_side_in.x       = req_ch.target_x;
      s1_side_in.y       = req_ch.target_y;
      s1_side_in.unreach = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff <= req_ch.valid;
      end
      if (en) begin
         s1_side_ff <= s1_side_in;
         s1_xx_ff   <= req_ch.target_x * req_ch.target_x;
         s1_yy_ff   <= req_ch.target_y * req_ch.target_y;
         s1_l1sq_ff <= upper_ff * upper_ff;
         s1_l2sq_ff <= lower_ff * lower_ff;
         s1_l1l2_ff <= upper_ff * lower_ff;
      end
   end

   // S2: numerator and denominator of cos2
   tlik_pkg::side_type            s2_side_ff;
   logic signed [tlik_pkg::NUMW-1:0] s2_num_ff, s2_num_in;
   logic [DENW-1:0]               s2_den_ff, s2_den_in;
   logic                          s2_vld_ff;

   always_comb begin
      s2_num_in = tlik_pkg::NUMW'(s1_xx_ff) + tlik_pkg::NUMW'(s1_yy_ff)
                - $signed(tlik_pkg::NUMW'(s1_l1sq_ff)) - $signed(tlik_pkg::NUMW'(s1_l2sq_ff));
      s2_den_in = {s1_l1l2_ff, 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (en) begin
         s2_vld_ff <= s1_vld_ff;
      end
      if (en) begin
         s2_side_ff <= s1_side_ff;
         s2_num_ff  <= s2_num_in;
         s2_den_ff  <= s2_den_in;
      end
   end

   // S3 .. divider: cos2 magnitude = round(|num| * 2^14 / den)
   tlik_pkg::div_type   div_ff  [0:QW];
   tlik_pkg::side_type  dside_ff [0:QW];
   logic                dvld_ff [0:QW];

   logic [tlik_pkg::ABSW-1:0] absn;
   logic [DIVW+1:0]           dividend;
   tlik_pkg::div_type         div0_in;
   tlik_pkg::side_type        dside0_in;

   always_comb begin
      absn     = s2_num_ff[tlik_pkg::NUMW-1] ? tlik_pkg::ABSW'(-s2_num_ff)
                                              : tlik_pkg::ABSW'(s2_num_ff);
      dividend = {absn[DIVW-13:0], 14'b0} + (DIVW+2)'(s2_den_ff >> 1);
      div0_in.n   = dividend[DIVW-1:0];
      div0_in.r   = dividend[DIVW-1:QW];
      div0_in.q   = '0;
      div0_in.den = s2_den_ff;
      div0_in.neg = s2_num_ff[tlik_pkg::NUMW-1];
      dside0_in         = s2_side_ff;
      dside0_in.unreach = (s2_den_ff == '0) || (absn > tlik_pkg::ABSW'(s2_den_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dvld_ff[0] <= 1'b0;
      end else if (en) begin
         dvld_ff[0] <= s2_vld_ff;
      end
      if (en) begin
         div_ff[0]   <= div0_in;
         dside_ff[0] <= dside0_in;
      end
   end

   for (genvar j = 0; j < QW; j++) begin : g_div
      logic [DENW:0]     r2;
      logic              ge;
      tlik_pkg::div_type d_in;

      always_comb begin
         r2        = {div_ff[j].r, div_ff[j].n[QW-1-j]};
         ge        = r2 >= {1'b0, div_ff[j].den};
         d_in      = div_ff[j];
         d_in.r    = ge ? DENW'(r2 - {1'b0, div_ff[j].den}) : r2[DENW-1:0];
         d_in.q    = {div_ff[j].q[QW-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dvld_ff[j+1] <= 1'b0;
         end else if (en) begin
            dvld_ff[j+1] <= dvld_ff[j];
         end
         if (en) begin
            div_ff[j+1]   <= d_in;
            dside_ff[j+1] <= dside_ff[j];
         end
      end
   end

   // S4: signed cos2, clamped when out of reach
   tlik_pkg::side_type     s4_side_ff;
   logic signed [C2W-1:0]  s4_c2_ff, s4_c2_in;
   logic [QW-1:0]          c2_mag;
   logic                   s4_vld_ff;

   always_comb begin
      c2_mag   = dside_ff[QW].unreach ? tlik_pkg::ONE_Q14 : div_ff[QW].q;
      s4_c2_in = div_ff[QW].neg ? -$signed(C2W'(c2_mag)) : $signed(C2W'(c2_mag));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else if (en) begin
         s4_vld_ff <= dvld_ff[QW];
      end
      if (en) begin
         s4_side_ff <= dside_ff[QW];
         s4_c2_ff   <= s4_c2_in;
      end
   end

   // S5: cos2 squared
   tlik_pkg::side_type      s5_side_ff;
   logic signed [C2W-1:0]   s5_c2_ff;
   logic signed [2*C2W-1:0] s5_csq_ff;
   logic                    s5_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_vld_ff <= 1'b0;
      end else if (en) begin
         s5_vld_ff <= s4_vld_ff;
      end
      if (en) begin
         s5_side_ff <= s4_side_ff;
         s5_c2_ff   <= s4_c2_ff;
         s5_csq_ff  <= s4_c2_ff * s4_c2_ff;
      end
   end

   // square root pipeline: sin2 = sqrt(2^28 - cos2^2)
   tlik_pkg::sqrt_type  sq_ff    [0:QW];
   tlik_pkg::side_type  sside_ff [0:QW];
   logic                svld_ff  [0:QW];
   tlik_pkg::sqrt_type  sq0_in;

   always_comb begin
      sq0_in.rem  = SQW'(29'h1000_0000 - s5_csq_ff[SQW-1:0]);
      sq0_in.root = '0;
      sq0_in.c2   = s5_c2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         svld_ff[0] <= 1'b0;
      end else if (en) begin
         svld_ff[0] <= s5_vld_ff;
      end
      if (en) begin
         sq_ff[0]    <= sq0_in;
         sside_ff[0] <= s5_side_ff;
      end
   end

   for (genvar j = 0; j < QW; j++) begin : g_sqrt
      localparam int B = QW - 1 - j;
      logic [TW-1:0]      trial;
      logic               ge;
      tlik_pkg::sqrt_type s_in;

      always_comb begin
         trial     = (TW'(sq_ff[j].root) << (B + 1)) + (TW'(1) << (2 * B));
         ge        = TW'(sq_ff[j].rem) >= trial;
         s_in      = sq_ff[j];
         s_in.rem  = ge ? SQW'(TW'(sq_ff[j].rem) - trial) : sq_ff[j].rem;
         s_in.root = ge ? (sq_ff[j].root | (QW'(1) << B)) : sq_ff[j].root;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            svld_ff[j+1] <= 1'b0;
         end else if (en) begin
            svld_ff[j+1] <= svld_ff[j];
         end
         if (en) begin
            sq_ff[j+1]    <= s_in;
            sside_ff[j+1] <= sside_ff[j];
         end
      end
   end

   // S6: round sin2 to nearest
   tlik_pkg::side_type    s6_side_ff;
   logic signed [C2W-1:0] s6_c2_ff;
   logic [QW-1:0]         s6_s2_ff, s6_s2_in;
   logic                  s6_vld_ff;

   assign s6_s2_in = sq_ff[QW].root
                   + QW'(sq_ff[QW].rem > SQW'(sq_ff[QW].root));

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_vld_ff <= 1'b0;
      end else if (en) begin
         s6_vld_ff <= svld_ff[QW];
      end
      if (en) begin
         s6_side_ff <= sside_ff[QW];
         s6_c2_ff   <= sq_ff[QW].c2;
         s6_s2_ff   <= s6_s2_in;
      end
   end

   // S7: L2*cos2 and k2 = L2*sin2
   tlik_pkg::side_type    s7_side_ff;
   logic signed [C2W-1:0] s7_c2_ff;
   logic [QW-1:0]         s7_s2_ff;
   logic signed [KW-1:0]  s7_p_ff, s7_k2_ff;
   logic signed [KW:0]    l2c2;
   logic [LW+QW-1:0]      l2s2;
   logic                  s7_vld_ff;

   always_comb begin
      l2c2 = $signed({1'b0, lower_ff}) * s6_c2_ff;
      l2s2 = lower_ff * s6_s2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_vld_ff <= 1'b0;
      end else if (en) begin
         s7_vld_ff <= s6_vld_ff;
      end
      if (en) begin
         s7_side_ff <= s6_side_ff;
         s7_c2_ff   <= s6_c2_ff;
         s7_s2_ff   <= s6_s2_ff;
         s7_p_ff    <= l2c2[KW-1:0];
         s7_k2_ff   <= $signed(KW'(l2s2));
      end
   end

   // S8: k1 = L1*2^14 + L2*cos2, singular shoulder check
   tlik_pkg::side_type    s8_side_ff, s8_side_in;
   logic signed [C2W-1:0] s8_c2_ff;
   logic [QW-1:0]         s8_s2_ff;
   logic signed [KW-1:0]  s8_k1_ff, s8_k1_in, s8_k2_ff;
   logic                  s8_vld_ff;

   always_comb begin
      s8_k1_in           = $signed({2'b00, upper_ff, 14'b0}) + s7_p_ff;
      s8_side_in         = s7_side_ff;
      s8_side_in.unreach = s7_side_ff.unreach || ((s8_k1_in == '0) && (s7_k2_ff == '0));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s8_vld_ff <= 1'b0;
      end else if (en) begin
         s8_vld_ff <= s7_vld_ff;
      end
      if (en) begin
         s8_side_ff <= s8_side_in;
         s8_c2_ff   <= s7_c2_ff;
         s8_s2_ff   <= s7_s2_ff;
         s8_k1_ff   <= s8_k1_in;
         s8_k2_ff   <= s7_k2_ff;
      end
   end

   // S9: cross products
   logic                  s9_unreach_ff;
   logic signed [C2W-1:0] s9_c2_ff;
   logic [QW-1:0]         s9_s2_ff;
   logic signed [PW-1:0]  s9_k1x_ff, s9_k2y_ff, s9_k2x_ff, s9_k1y_ff;
   logic                  s9_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s9_vld_ff <= 1'b0;
      end else if (en) begin
         s9_vld_ff <= s8_vld_ff;
      end
      if (en) begin
         s9_unreach_ff <= s8_side_ff.unreach;
         s9_c2_ff      <= s8_c2_ff;
         s9_s2_ff      <= s8_s2_ff;
         s9_k1x_ff     <= s8_k1_ff * s8_side_ff.x;
         s9_k2y_ff     <= s8_k2_ff * s8_side_ff.y;
         s9_k2x_ff     <= s8_k2_ff * s8_side_ff.x;
         s9_k1y_ff     <= s8_k1_ff * s8_side_ff.y;
      end
   end

   // S10: atan2 operands
   logic                 s10_unreach_ff;
   logic signed [CW-1:0] s10_a_ff, s10_b_ff, s10_ey_ff, s10_ex_ff;
   logic signed [ABW-1:0] a_in, b_in;
   logic                 s10_vld_ff;

   always_comb begin
      a_in = ABW'(s9_k1x_ff) + ABW'(s9_k2y_ff);
      b_in = ABW'(s9_k2x_ff) - ABW'(s9_k1y_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s10_vld_ff <= 1'b0;
      end else if (en) begin
         s10_vld_ff <= s9_vld_ff;
      end
      if (en) begin
         s10_unreach_ff <= s9_unreach_ff;
         s10_a_ff       <= CW'(a_in);
         s10_b_ff       <= CW'(b_in);
         s10_ey_ff      <= $signed({17'b0, s9_s2_ff, 24'b0});
         s10_ex_ff      <= $signed({{(CW-C2W-24){s9_c2_ff[C2W-1]}}, s9_c2_ff, 24'b0});
      end
   end

   // atan2 units
   logic                          sh_vld, sh_tag, el_vld, el_tag;
   logic signed [tlik_pkg::AW-1:0] sh_angle, el_angle;

   tlik_cordic u_shoulder (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s10_vld_ff),
      .in_tag    (s10_unreach_ff),
      .in_y      (s10_a_ff),
      .in_x      (s10_b_ff),
      .out_valid (sh_vld),
      .out_tag   (sh_tag),
      .out_angle (sh_angle)
   );

   tlik_cordic u_elbow (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s10_vld_ff),
      .in_tag    (s10_unreach_ff),
      .in_y      (s10_ey_ff),
      .in_x      (s10_ex_ff),
      .out_valid (el_vld),
      .out_tag   (el_tag),
      .out_angle (el_angle)
   );

   // response register
   logic signed [tlik_pkg::AW-1:0] out_sh_ff, out_el_ff;
   logic                           out_unreach_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (en) begin
         out_vld_ff <= sh_vld;
      end
      if (en) begin
         out_sh_ff      <= sh_angle;
         out_el_ff      <= el_angle;
         out_unreach_ff <= sh_tag;
      end
   end

   assign rsp_ch.valid          = out_vld_ff;
   assign rsp_ch.shoulder_angle = out_sh_ff;
   assign rsp_ch.elbow_angle    = out_el_ff;
   assign rsp_ch.unreachable    = out_unreach_ff;

   `TLIK_ASSERT(a_cordic_lockstep, clock, reset, (sh_vld == el_vld) && (!sh_vld || (sh_tag == el_tag)), "atan2 units out of step")
   `TLIK_ASSERT(a_cos2_range, clock, reset, (dvld_ff[QW] && !dside_ff[QW].unreach) |-> (div_ff[QW].q <= tlik_pkg::ONE_Q14), "cos2 quotient above one")
   `TLIK_ASSERT(a_elbow_range, clock, reset, rsp_ch.valid |-> ((rsp_ch.elbow_angle >= 0) && (rsp_ch.elbow_angle <= tlik_pkg::ELBOW_LIMIT)), "elbow angle outside 0..pi")
   `TLIK_ASSERT(a_hold_stall, clock, reset, (out_vld_ff && !en) |=> (out_vld_ff && $stable(sh_angle)), "pipeline moved while stalled")

endmodule
